/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies property in the same cycle.
`define ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Condition implies property in the next cycle.
`define ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

/* rtl/tgarle_pkg.sv */
// Types and constants for the TGA RLE true-color decoder.
// Used by every module of the block; depends on nothing.
package tgarle_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [1:0] copies;
    logic       last_of_run;
    logic       image_done;
  } out_t;

  // One finished pixel with the number of positions it fills.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] count;
    logic       done;
  } job_t;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_IN_STREAM = 2'd2;

  localparam logic [15:0] RESET_WIDTH  = 16'd64;
  localparam logic [15:0] RESET_HEIGHT = 16'd64;
  localparam logic [31:0] RESET_TOTAL  = 32'd4096;

  localparam logic [23:0] KEY_COLOR    = 24'hFF00FF;
  localparam logic [7:0]  ALPHA_KEYED  = 8'h00;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

endpackage

/* rtl/tgarle_fifo.sv */
// Small job queue between the parser front and the expander back.
// Depends on tgarle_pkg for the job type.
module tgarle_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  tgarle_pkg::job_t  wr_data,
  input  logic              rd_en,
  output tgarle_pkg::job_t  rd_data,
  output logic              full,
  output logic              empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tgarle_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/tgarle_front.sv */
// Byte parser: configuration, packet headers, pixel gathering, image count.
// Depends on tgarle_pkg; emits one job per finished pixel into the queue.
module tgarle_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  tgarle_pkg::in_t                      item,
  input  logic                                 q_full,
  input  logic                                 cfg_we,
  input  logic [tgarle_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                 job_we,
  output tgarle_pkg::job_t                     job
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_BLUE   = 3'd1,
    PH_GREEN  = 3'd2,
    PH_RED    = 3'd3,
    PH_ALPHA  = 3'd4
  } phase_t;

  logic [15:0] width;
  logic [15:0] height;
  logic        alpha_mode;
  logic [31:0] total;

  phase_t      phase, phase_next;
  logic        is_run, is_run_next;
  logic [7:0]  left, left_next;
  logic [23:0] color, color_next;
  logic [31:0] written, written_next;
  logic        done, done_next;

  phase_t      phase_w;
  logic        is_run_w;
  logic [7:0]  left_w;
  logic [31:0] written_w;
  logic        done_w;
  logic        accept;
  logic        finish;
  logic [7:0]  fin_alpha;
  logic [7:0]  n;
  logic [31:0] rem;
  logic [7:0]  m;
  logic        hit_end;

  assign accept = push && !q_full;

  always_comb begin
    phase_w   = phase;
    is_run_w  = is_run;
    left_w    = left;
    written_w = written;
    done_w    = done;
    color_next = color;
    if (accept && item.frame_start) begin
      phase_w    = PH_HEADER;
      is_run_w   = 1'b0;
      left_w     = '0;
      written_w  = '0;
      done_w     = 1'b0;
      color_next = '0;
    end
    phase_next   = phase_w;
    is_run_next  = is_run_w;
    left_next    = left_w;
    written_next = written_w;
    done_next    = done_w;
    finish       = 1'b0;
    fin_alpha    = item.data_byte;
    if (accept && !done_w && (written_w < total)) begin
      unique case (phase_w)
        PH_BLUE: begin
          color_next[7:0] = item.data_byte;
          phase_next      = PH_GREEN;
        end
        PH_GREEN: begin
          color_next[15:8] = item.data_byte;
          phase_next       = PH_RED;
        end
        PH_RED: begin
          color_next[23:16] = item.data_byte;
          if (alpha_mode) begin
            phase_next = PH_ALPHA;
          end else begin
            finish    = 1'b1;
            fin_alpha = (color_next == tgarle_pkg::KEY_COLOR) ?
                        tgarle_pkg::ALPHA_KEYED : tgarle_pkg::ALPHA_OPAQUE;
          end
        end
        PH_ALPHA: begin
          finish    = 1'b1;
          fin_alpha = item.data_byte;
        end
        default: begin
          is_run_next = item.data_byte[7];
          left_next   = {1'b0, item.data_byte[6:0]} + 8'd1;
          phase_next  = PH_BLUE;
        end
      endcase
    end
    n       = is_run_w ? left_w : 8'd1;
    rem     = total - written_w;
    hit_end = ({24'd0, n} >= rem);
    m       = hit_end ? rem[7:0] : n;
    if (finish) begin
      written_next = written_w + {24'd0, m};
      if (is_run_w) begin
        left_next  = '0;
        phase_next = PH_HEADER;
      end else begin
        left_next  = left_w - 8'd1;
        phase_next = (left_w == 8'd1) ? PH_HEADER : PH_BLUE;
      end
      if (hit_end) begin
        done_next  = 1'b1;
        left_next  = '0;
        phase_next = PH_HEADER;
      end
    end
  end

  assign job_we     = finish;
  assign job.blue   = color_next[7:0];
  assign job.green  = color_next[15:8];
  assign job.red    = color_next[23:16];
  assign job.alpha  = fin_alpha;
  assign job.count  = m;
  assign job.done   = hit_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      width      <= tgarle_pkg::RESET_WIDTH;
      height     <= tgarle_pkg::RESET_HEIGHT;
      alpha_mode <= 1'b0;
      total      <= tgarle_pkg::RESET_TOTAL;
      phase      <= PH_HEADER;
      is_run     <= 1'b0;
      left       <= '0;
      color      <= '0;
      written    <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tgarle_pkg::REG_IMAGE_WIDTH: begin
            width <= cfg_data;
            total <= 32'(cfg_data) * 32'(height);
          end
          tgarle_pkg::REG_IMAGE_HEIGHT: begin
            height <= cfg_data;
            total  <= 32'(width) * 32'(cfg_data);
          end
          tgarle_pkg::REG_ALPHA_IN_STREAM: begin
            alpha_mode <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      phase   <= phase_next;
      is_run  <= is_run_next;
      left    <= left_next;
      color   <= color_next;
      written <= written_next;
      done    <= done_next;
    end
  end

endmodule

/* rtl/tgarle_back.sv */
// Expander: turns each job into results of up to two copies each.
// Depends on tgarle_pkg; drives the registered result stage.
module tgarle_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  tgarle_pkg::job_t  q_job,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output tgarle_pkg::out_t  result
);

  logic             out_valid;
  logic             busy;
  tgarle_pkg::job_t cur;
  logic [7:0]       rem;

  logic             advance;
  logic             src_valid;
  tgarle_pkg::job_t src_job;
  logic [7:0]       src_cnt;
  logic             fire;
  logic             last;

  always_comb begin
    advance   = !out_valid || pop;
    src_valid = busy || q_valid;
    src_job   = busy ? cur : q_job;
    src_cnt   = busy ? rem : q_job.count;
    fire      = advance && src_valid;
    last      = (src_cnt <= 8'd2);
    q_pop     = fire && !busy;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= src_valid;
      end
      if (fire) begin
        busy <= !last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.blue        <= src_job.blue;
      result.green       <= src_job.green;
      result.red         <= src_job.red;
      result.alpha       <= src_job.alpha;
      result.copies      <= (src_cnt >= 8'd2) ? 2'd2 : 2'd1;
      result.last_of_run <= last;
      result.image_done  <= last && src_job.done;
      cur                <= src_job;
      rem                <= src_cnt - 8'd2;
    end
  end

endmodule

/* rtl/tga_rle_truecolor_decoder.sv */
// TGA RLE true-color decoder: one compressed byte in per beat, BGRA results out.
// A byte that finishes a pixel is written into the job queue, then registered in the expander's result stage.
// Throughput: one byte per cycle; a run of n pixels drains ceil(n/2) results, one
// per cycle from the expander while results are popped, and input stalls only when the job queue fills.
// Reset (rst, synchronous): 64x64 image, 24-bit mode, parser and queue clear, result stage empties.
module tga_rle_truecolor_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  tgarle_pkg::in_t                     item,
  output logic                                empty,
  input  logic                                pop,
  output tgarle_pkg::out_t                    result,
  input  logic                                cfg_we,
  input  logic [tgarle_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic             job_we;
  tgarle_pkg::job_t job;
  tgarle_pkg::job_t q_job;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;

  assign full = q_full;

  tgarle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .q_full    (q_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_we    (job_we),
    .job       (job)
  );

  tgarle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_we),
    .wr_data (job),
    .rd_en   (q_pop),
    .rd_data (q_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  tgarle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (!q_empty),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

/* rtl/tgarle_checker.sv */
// Port-level checks on the decoder's result stream.
// Depends on tgarle_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module tgarle_checker (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input tgarle_pkg::out_t result
);

  `ASSERT_NEXT(hold_result, !empty && !pop, !empty && $stable(result))
  `ASSERT_SAME(copies_legal, !empty, result.copies == 2'd1 || result.copies == 2'd2)
  `ASSERT_SAME(done_ends_byte, !empty && result.image_done, result.last_of_run)
  `ASSERT_SAME(pair_unless_last, !empty && !result.last_of_run, result.copies == 2'd2)

endmodule

bind tga_rle_truecolor_decoder tgarle_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
